// ===== sv/lfpd_pkg.sv =====
// ============================================================================
// lfpd_pkg
// Shared types and constants of the line follower PID drive: register
// indexes, motor direction codes, sensor weights and controller commands.
// ============================================================================
`default_nettype none

package lfpd_pkg;

    localparam int MAX_SENSORS = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int GAIN_W      = 16;
    localparam int SPEED_W     = 9;
    localparam int THR_W       = 10;
    localparam int ERR_W       = 4;
    localparam int INTEG_W     = 16;
    localparam int DUTY_W      = 8;
    localparam int DIR_W       = 2;
    localparam int SUM_W       = 6;
    localparam int MAG_W       = 4;
    localparam int DIV_STEPS   = MAG_W;
    localparam int PROD_W      = 34;
    localparam int ACC_W       = 36;
    localparam int FRAC_BITS   = 8;
    localparam int CORR_W      = ACC_W - FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 3'd4;

    localparam logic [GAIN_W-1:0]         PROP_GAIN_RESET  = 16'd1920;
    localparam logic [GAIN_W-1:0]         INTEG_GAIN_RESET = 16'd26;
    localparam logic [GAIN_W-1:0]         DERIV_GAIN_RESET = 16'd640;
    localparam logic signed [SPEED_W-1:0] BASE_SPEED_RESET = 9'sd70;
    localparam logic [THR_W-1:0]          THRESHOLD_RESET  = 10'd800;

    localparam logic [DIR_W-1:0] DIR_OFF      = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd2;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 9'sd255;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -9'sd255;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 16'sh7FFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = 16'sh8000;

    localparam logic signed [ERR_W-1:0] SENSOR_WEIGHT [MAX_SENSORS] =
        '{4'sd7, 4'sd4, 4'sd2, 4'sd1, -4'sd1, -4'sd2, -4'sd4, -4'sd7};

    typedef enum logic [1:0] {
        MUL_PROP,
        MUL_INTEG,
        MUL_DERIV
    } mul_sel_t;

    typedef struct packed {
        logic     load_scan;
        logic     div_step;
        logic     prep;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_clear;
        logic     acc_add;
        logic     corr;
        logic     out_load;
    } lfpd_cmd_t;

    typedef struct packed {
        logic out_free;
    } lfpd_stat_t;

endpackage

`default_nettype wire

// ===== sv/lfpd_ifs.sv =====
// ============================================================================
// lfpd interfaces
// Valid/ready channels of the line follower PID drive: sensor scan input,
// motor drive result and configuration write.
// ============================================================================
`default_nettype none

interface lfpd_scan_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_0;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_4;
    logic [SAMPLE_BITS-1:0] sample_5;
    logic [SAMPLE_BITS-1:0] sample_6;
    logic [SAMPLE_BITS-1:0] sample_7;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7,
        input  ready
    );
    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3,
               sample_4, sample_5, sample_6, sample_7,
        output ready
    );
endinterface

interface lfpd_drive_if;
    logic              valid;
    logic              ready;
    logic [7:0]        left_duty;
    logic [1:0]        left_dir;
    logic [7:0]        right_duty;
    logic [1:0]        right_dir;
    logic              line_lost;
    logic signed [3:0] track_error;

    modport source (
        output valid, left_duty, left_dir, right_duty, right_dir, line_lost, track_error,
        input  ready
    );
    modport sink (
        input  valid, left_duty, left_dir, right_duty, right_dir, line_lost, track_error,
        output ready
    );
endinterface

interface lfpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/lfpd_ctrl.sv =====
// ============================================================================
// lfpd_ctrl
// Sequencer of the line follower PID drive. Steps the datapath through the
// hit-count division, the error and integral update, the three gain
// products, the accumulation, the correction and the result load.
// ============================================================================
`default_nettype none

module lfpd_ctrl
    import lfpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire lfpd_stat_t stat,
    output lfpd_cmd_t       cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_CORR,
        ST_DONE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_PROP;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_scan = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROP;
                state_next  = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_INTEG;
                cmd.acc_clear = 1'b1;
                state_next    = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DERIV;
                cmd.acc_add = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_CORR;
            end
            ST_CORR:
            begin
                cmd.corr   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lfpd_dp.sv =====
// ============================================================================
// lfpd_dp
// Datapath of the line follower PID drive: configuration registers, hit
// detection, bit-serial division, shared gain multiplier, accumulator,
// speed clamp and the result register.
// ============================================================================
`default_nettype none

module lfpd_dp
    import lfpd_pkg::*;
#(
    parameter int SENSOR_COUNT = 8,
    parameter int SAMPLE_BITS  = 10
)(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [SAMPLE_BITS-1:0] samples [MAX_SENSORS],
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire lfpd_cmd_t              cmd,
    output lfpd_stat_t                  stat,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [DUTY_W-1:0]           left_duty,
    output logic [DIR_W-1:0]            left_dir,
    output logic [DUTY_W-1:0]           right_duty,
    output logic [DIR_W-1:0]            right_dir,
    output logic                        line_lost,
    output logic signed [ERR_W-1:0]     track_error
);

    localparam int NUM_USED = (SENSOR_COUNT < MAX_SENSORS) ? SENSOR_COUNT : MAX_SENSORS;
    localparam int HIT_W    = $clog2(NUM_USED + 1);
    localparam int CMP_W    = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
    localparam int OPND_W   = INTEG_W + 1;
    localparam int LSUM_W   = CORR_W + 1;

    logic [GAIN_W-1:0]          prop_gain_reg;
    logic [GAIN_W-1:0]          integ_gain_reg;
    logic [GAIN_W-1:0]          deriv_gain_reg;
    logic signed [SPEED_W-1:0]  base_speed_reg;
    logic [THR_W-1:0]           threshold_reg;

    logic signed [INTEG_W-1:0]  integral_reg;
    logic signed [ERR_W-1:0]    prev_err_reg;
    logic                       out_valid_reg;

    logic [MAG_W-1:0]           dvd_reg;
    logic [MAG_W-1:0]           rem_reg;
    logic [MAG_W-1:0]           quo_reg;
    logic [HIT_W-1:0]           hits_reg;
    logic                       sum_neg_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic                       lost_reg;
    logic signed [INTEG_W-1:0]  integ_new_reg;
    logic signed [ERR_W:0]      diff_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [CORR_W-1:0]   corr_reg;

    logic [DUTY_W-1:0]          left_duty_reg;
    logic [DIR_W-1:0]           left_dir_reg;
    logic [DUTY_W-1:0]          right_duty_reg;
    logic [DIR_W-1:0]           right_dir_reg;
    logic                       line_lost_reg;
    logic signed [ERR_W-1:0]    track_error_reg;

    logic signed [SUM_W-1:0]    scan_sum;
    logic [HIT_W-1:0]           scan_hits;
    logic [SUM_W-1:0]           scan_abs;

    logic [MAG_W:0]             div_trial;
    logic [MAG_W:0]             div_divisor;
    logic                       div_ge;
    logic [MAG_W:0]             div_diff;

    logic                       prep_lost;
    logic signed [ERR_W-1:0]    prep_err;
    logic signed [INTEG_W:0]    prep_isum;
    logic signed [INTEG_W-1:0]  prep_integ;

    logic [GAIN_W-1:0]          mul_gain;
    logic signed [OPND_W-1:0]   mul_opnd;

    logic signed [ACC_W-1:0]    corr_biased;
    logic signed [LSUM_W-1:0]   left_sum;
    logic signed [LSUM_W-1:0]   right_sum;
    logic signed [SPEED_W-1:0]  left_spd;
    logic signed [SPEED_W-1:0]  right_spd;
    logic signed [SPEED_W-1:0]  left_neg;
    logic signed [SPEED_W-1:0]  right_neg;

    always_comb
    begin
        scan_sum  = '0;
        scan_hits = '0;
        for (int i = 0; i < NUM_USED; i++)
        begin
            if (CMP_W'(samples[i]) < CMP_W'(threshold_reg))
            begin
                scan_sum  = scan_sum + SUM_W'(SENSOR_WEIGHT[i]);
                scan_hits = scan_hits + 1'b1;
            end
        end
        scan_abs = scan_sum[SUM_W-1] ? SUM_W'(-scan_sum) : SUM_W'(scan_sum);
    end

    assign div_trial   = {rem_reg, dvd_reg[MAG_W-1]};
    assign div_divisor = (MAG_W + 1)'(hits_reg);
    assign div_ge      = (div_trial >= div_divisor);
    assign div_diff    = div_trial - div_divisor;

    always_comb
    begin
        prep_lost = (hits_reg == '0);
        if (prep_lost)
        begin
            prep_err = '0;
        end
        else if (sum_neg_reg)
        begin
            prep_err = $signed(ERR_W'(-quo_reg));
        end
        else
        begin
            prep_err = $signed(quo_reg);
        end
        prep_isum = (INTEG_W + 1)'(integral_reg) + (INTEG_W + 1)'(prep_err);
        if (prep_isum[INTEG_W] != prep_isum[INTEG_W-1])
        begin
            prep_integ = prep_isum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
        end
        else
        begin
            prep_integ = prep_isum[INTEG_W-1:0];
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_PROP:
            begin
                mul_gain = prop_gain_reg;
                mul_opnd = OPND_W'(err_reg);
            end
            MUL_INTEG:
            begin
                mul_gain = integ_gain_reg;
                mul_opnd = OPND_W'(integ_new_reg);
            end
            MUL_DERIV:
            begin
                mul_gain = deriv_gain_reg;
                mul_opnd = OPND_W'(diff_reg);
            end
            default:
            begin
                mul_gain = '0;
                mul_opnd = '0;
            end
        endcase
    end

    always_comb
    begin
        corr_biased = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
        left_sum    = LSUM_W'(base_speed_reg) + LSUM_W'(corr_reg);
        right_sum   = LSUM_W'(base_speed_reg) - LSUM_W'(corr_reg);
        if (left_sum > LSUM_W'(SPEED_MAX))
        begin
            left_spd = SPEED_MAX;
        end
        else if (left_sum < LSUM_W'(SPEED_MIN))
        begin
            left_spd = SPEED_MIN;
        end
        else
        begin
            left_spd = left_sum[SPEED_W-1:0];
        end
        if (right_sum > LSUM_W'(SPEED_MAX))
        begin
            right_spd = SPEED_MAX;
        end
        else if (right_sum < LSUM_W'(SPEED_MIN))
        begin
            right_spd = SPEED_MIN;
        end
        else
        begin
            right_spd = right_sum[SPEED_W-1:0];
        end
        left_neg  = -left_spd;
        right_neg = -right_spd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RESET;
            integ_gain_reg <= INTEG_GAIN_RESET;
            deriv_gain_reg <= DERIV_GAIN_RESET;
            base_speed_reg <= BASE_SPEED_RESET;
            threshold_reg  <= THRESHOLD_RESET;
            integral_reg   <= '0;
            prev_err_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:      prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN:     integ_gain_reg <= cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN:     deriv_gain_reg <= cfg_data[GAIN_W-1:0];
                    REG_BASE_SPEED:     base_speed_reg <= $signed(cfg_data[SPEED_W-1:0]);
                    REG_LINE_THRESHOLD: threshold_reg  <= cfg_data[THR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.prep)
            begin
                integral_reg <= prep_integ;
                prev_err_reg <= prep_err;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_scan)
        begin
            dvd_reg     <= scan_abs[MAG_W-1:0];
            rem_reg     <= '0;
            quo_reg     <= '0;
            hits_reg    <= scan_hits;
            sum_neg_reg <= scan_sum[SUM_W-1];
        end
        if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[MAG_W-2:0], 1'b0};
            rem_reg <= div_ge ? div_diff[MAG_W-1:0] : div_trial[MAG_W-1:0];
            quo_reg <= {quo_reg[MAG_W-2:0], div_ge};
        end
        if (cmd.prep)
        begin
            err_reg       <= prep_err;
            lost_reg      <= prep_lost;
            integ_new_reg <= prep_integ;
            diff_reg      <= (ERR_W + 1)'(prep_err) - (ERR_W + 1)'(prev_err_reg);
        end
        if (cmd.mul_en)
        begin
            prod_reg <= $signed({1'b0, mul_gain}) * mul_opnd;
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= ACC_W'(prod_reg);
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.corr)
        begin
            corr_reg <= corr_biased[ACC_W-1:FRAC_BITS];
        end
        if (cmd.out_load)
        begin
            line_lost_reg   <= lost_reg;
            track_error_reg <= err_reg;
            if (lost_reg)
            begin
                left_dir_reg   <= DIR_OFF;
                left_duty_reg  <= '0;
                right_dir_reg  <= DIR_OFF;
                right_duty_reg <= '0;
            end
            else
            begin
                if (left_spd > 0)
                begin
                    left_dir_reg  <= DIR_FORWARD;
                    left_duty_reg <= left_spd[DUTY_W-1:0];
                end
                else
                begin
                    left_dir_reg  <= DIR_BACKWARD;
                    left_duty_reg <= left_neg[DUTY_W-1:0];
                end
                if (right_spd > 0)
                begin
                    right_dir_reg  <= DIR_FORWARD;
                    right_duty_reg <= right_spd[DUTY_W-1:0];
                end
                else
                begin
                    right_dir_reg  <= DIR_BACKWARD;
                    right_duty_reg <= right_neg[DUTY_W-1:0];
                end
            end
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign left_duty     = left_duty_reg;
    assign left_dir      = left_dir_reg;
    assign right_duty    = right_duty_reg;
    assign right_dir     = right_dir_reg;
    assign line_lost     = line_lost_reg;
    assign track_error   = track_error_reg;

endmodule

`default_nettype wire

// ===== sv/line_follower_pid_drive.sv =====
// ============================================================================
// line_follower_pid_drive
// PID motor drive for a line-following robot. Each scan beat of eight
// reflectance samples yields one drive beat with left and right direction
// and duty, the line-lost flag and the position error. On its way from
// acceptance to the result register a scan passes through the bit-serial
// division of the weighted sum by the hit count, the step for the error,
// the integral and the difference, the single shared gain multiplier and
// its accumulator, the correction and the speed clamp. A new scan is
// accepted as soon as the previous one has reached the result register,
// which holds its beat until it is taken.
// Configuration writes are accepted every cycle and belong in idle time.
// ============================================================================
`default_nettype none

module line_follower_pid_drive
    import lfpd_pkg::*;
#(
    parameter int SENSOR_COUNT = 8,
    parameter int SAMPLE_BITS  = 10
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lfpd_scan_if.sink   scan,
    lfpd_drive_if.source drive,
    lfpd_cfg_if.sink    cfg
);

    logic [SAMPLE_BITS-1:0] samples [MAX_SENSORS];
    lfpd_cmd_t              cmd;
    lfpd_stat_t             stat;

    assign samples[0] = SAMPLE_BITS'(scan.sample_0);
    assign samples[1] = SAMPLE_BITS'(scan.sample_1);
    assign samples[2] = SAMPLE_BITS'(scan.sample_2);
    assign samples[3] = SAMPLE_BITS'(scan.sample_3);
    assign samples[4] = SAMPLE_BITS'(scan.sample_4);
    assign samples[5] = SAMPLE_BITS'(scan.sample_5);
    assign samples[6] = SAMPLE_BITS'(scan.sample_6);
    assign samples[7] = SAMPLE_BITS'(scan.sample_7);

    assign cfg.ready = 1'b1;

    lfpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (scan.valid),
        .in_ready (scan.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfpd_dp #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (drive.valid),
        .out_ready   (drive.ready),
        .left_duty   (drive.left_duty),
        .left_dir    (drive.left_dir),
        .right_duty  (drive.right_duty),
        .right_dir   (drive.right_dir),
        .line_lost   (drive.line_lost),
        .track_error (drive.track_error)
    );

    // A scan is worked on alone, so an accepted beat drops ready next cycle.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        scan.valid && scan.ready |=> !scan.ready
    ) else $error("scan accepted while a scan is in progress");

    a_lost_stops_motors: assert property (
        @(posedge clk) disable iff (!rst_n)
        drive.valid && drive.line_lost |->
            drive.left_dir == DIR_OFF && drive.right_dir == DIR_OFF &&
            drive.left_duty == '0 && drive.right_duty == '0 &&
            drive.track_error == '0
    ) else $error("line lost but motors not stopped");

    a_tracking_drives: assert property (
        @(posedge clk) disable iff (!rst_n)
        drive.valid && !drive.line_lost |->
            (drive.left_dir == DIR_FORWARD || drive.left_dir == DIR_BACKWARD) &&
            (drive.right_dir == DIR_FORWARD || drive.right_dir == DIR_BACKWARD)
    ) else $error("invalid direction while tracking");

    a_error_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        drive.valid |-> drive.track_error != 4'sb1000
    ) else $error("track error out of range");

endmodule

`default_nettype wire

// ===== tb/tb_line_follower_pid_drive.sv =====
// ============================================================================
// tb_line_follower_pid_drive
// Self-checking testbench for the line follower PID drive. Scan beats are
// driven on the scan channel, and a predictor with its own copy of the
// registers, the error integral and the previous error works out each drive
// beat. Drive beats are compared field by field in order of arrival. The run
// covers directed line positions, several register settings with random
// scans and random stalls on both channels, and runs to one side that push
// the integral up and then back down.
// ============================================================================
`timescale 1ns / 100ps

module tb_line_follower_pid_drive;
    import lfpd_pkg::*;

    typedef logic [MAX_SENSORS-1:0][THR_W-1:0] scan_vec_t;

    typedef struct {
        logic [DUTY_W-1:0]       left_duty;
        logic [DIR_W-1:0]        left_dir;
        logic [DUTY_W-1:0]       right_duty;
        logic [DIR_W-1:0]        right_dir;
        logic                    line_lost;
        logic signed [ERR_W-1:0] track_error;
    } drive_beat_t;

    typedef struct {
        logic [CFG_DATA_W-1:0] prop_gain;
        logic [CFG_DATA_W-1:0] integ_gain;
        logic [CFG_DATA_W-1:0] deriv_gain;
        logic [CFG_DATA_W-1:0] base_speed;
        logic [CFG_DATA_W-1:0] line_threshold;
    } drive_settings_t;

    localparam logic [MAX_SENSORS-1:0] LINE_MASKS [21] = '{
        8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
        8'h03, 8'hC0, 8'h11, 8'h18, 8'h07, 8'hE0, 8'h3C, 8'h0F, 8'hF0, 8'h81,
        8'h06
    };

    class pid_drive_predictor;
        int prop_gain;
        int integ_gain;
        int deriv_gain;
        int base_speed;
        int line_threshold;
        int error_integral;
        int previous_error;
        drive_beat_t pending_drives[$];
        int mismatches;

        function new();
            prop_gain      = int'(PROP_GAIN_RESET);
            integ_gain     = int'(INTEG_GAIN_RESET);
            deriv_gain     = int'(DERIV_GAIN_RESET);
            base_speed     = int'(BASE_SPEED_RESET);
            line_threshold = int'(THRESHOLD_RESET);
            error_integral = 0;
            previous_error = 0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PROP_GAIN:      prop_gain = int'(data);
                REG_INTEG_GAIN:     integ_gain = int'(data);
                REG_DERIV_GAIN:     deriv_gain = int'(data);
                REG_BASE_SPEED:     base_speed = int'($signed(data[SPEED_W-1:0]));
                REG_LINE_THRESHOLD: line_threshold = int'(data[THR_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void motor_out(longint speed, output logic [DUTY_W-1:0] duty,
                                output logic [DIR_W-1:0] dir);
            if (speed > 0)
            begin
                dir  = DIR_FORWARD;
                duty = speed[DUTY_W-1:0];
            end
            else
            begin
                dir  = DIR_BACKWARD;
                duty = DUTY_W'(-speed);
            end
        endfunction

        function void take_scan(scan_vec_t s);
            int sum;
            int hits;
            int err;
            longint integ;
            longint total;
            longint corr;
            drive_beat_t exp;

            sum  = 0;
            hits = 0;
            err  = 0;
            for (int i = 0; i < MAX_SENSORS; i++)
            begin
                if (int'(s[i]) < line_threshold)
                begin
                    sum += int'(SENSOR_WEIGHT[i]);
                    hits++;
                end
            end
            if (hits != 0)
                err = sum / hits;

            integ = clamp(longint'(error_integral) + err, -32768, 32767);
            total = longint'(prop_gain) * err + longint'(integ_gain) * integ
                  + longint'(deriv_gain) * (err - previous_error);
            corr = total / 256;
            error_integral = int'(integ);
            previous_error = err;

            if (hits == 0)
            begin
                exp.left_duty  = '0;
                exp.left_dir   = DIR_OFF;
                exp.right_duty = '0;
                exp.right_dir  = DIR_OFF;
            end
            else
            begin
                motor_out(clamp(base_speed + corr, -255, 255), exp.left_duty, exp.left_dir);
                motor_out(clamp(base_speed - corr, -255, 255), exp.right_duty, exp.right_dir);
            end
            exp.line_lost   = (hits == 0);
            exp.track_error = err[ERR_W-1:0];
            pending_drives.push_back(exp);
        endfunction

        function void compare_field(string name, logic signed [31:0] e, logic signed [31:0] a);
            if (a !== e)
            begin
                mismatches++;
                $display("%0t: %s expected %0d got %0d", $time, name, e, a);
            end
        endfunction

        function void check_drive(drive_beat_t got);
            drive_beat_t exp;

            if (pending_drives.size() == 0)
            begin
                mismatches++;
                $display("%0t: drive beat expected none got lost=%0d err=%0d", $time,
                         got.line_lost, got.track_error);
                return;
            end
            exp = pending_drives.pop_front();
            compare_field("left_duty", exp.left_duty, got.left_duty);
            compare_field("left_dir", exp.left_dir, got.left_dir);
            compare_field("right_duty", exp.right_duty, got.right_duty);
            compare_field("right_dir", exp.right_dir, got.right_dir);
            compare_field("line_lost", exp.line_lost, got.line_lost);
            compare_field("track_error", exp.track_error, got.track_error);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   gaps_on;
    int   sink_stall;

    pid_drive_predictor drive_pred;

    lfpd_scan_if #(.SAMPLE_BITS(THR_W)) scan_ch();
    lfpd_drive_if drive_ch();
    lfpd_cfg_if cfg_ch();

    line_follower_pid_drive dut (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan_ch),
        .drive (drive_ch),
        .cfg   (cfg_ch)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (sink_stall > 0)
        begin
            drive_ch.ready <= 1'b0;
            sink_stall--;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            drive_ch.ready <= 1'b0;
            sink_stall = $urandom_range(0, 4);
        end
        else
            drive_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        drive_beat_t got;

        if (rst_n && drive_ch.valid && drive_ch.ready)
        begin
            got.left_duty   = drive_ch.left_duty;
            got.left_dir    = drive_ch.left_dir;
            got.right_duty  = drive_ch.right_duty;
            got.right_dir   = drive_ch.right_dir;
            got.line_lost   = drive_ch.line_lost;
            got.track_error = drive_ch.track_error;
            drive_pred.check_drive(got);
        end
    end

    function automatic scan_vec_t scan_from_mask(logic [MAX_SENSORS-1:0] mask,
                                                 logic [THR_W-1:0] hit_val,
                                                 logic [THR_W-1:0] miss_val);
        scan_vec_t s;

        for (int i = 0; i < MAX_SENSORS; i++)
            s[i] = mask[i] ? hit_val : miss_val;
        return s;
    endfunction

    function automatic scan_vec_t random_scan(int thr);
        scan_vec_t s;
        int mode;
        int lo;
        int width;
        bit hit;

        mode  = (thr == 0) ? 0 : $urandom_range(0, 3);
        lo    = $urandom_range(0, MAX_SENSORS - 1);
        width = $urandom_range(1, 3);
        for (int i = 0; i < MAX_SENSORS; i++)
        begin
            case (mode)
                1: hit = 1'($urandom_range(0, 1));
                2: hit = (i >= lo) && (i < lo + width);
                default: hit = 1'b0;
            endcase
            if (mode == 0)
                s[i] = THR_W'($urandom_range(0, 1023));
            else if (hit)
                s[i] = THR_W'($urandom_range(0, thr - 1));
            else
                s[i] = THR_W'($urandom_range(thr, 1023));
        end
        return s;
    endfunction

    task automatic send_scan(scan_vec_t s);
        scan_ch.valid    <= 1'b1;
        scan_ch.sample_0 <= s[0];
        scan_ch.sample_1 <= s[1];
        scan_ch.sample_2 <= s[2];
        scan_ch.sample_3 <= s[3];
        scan_ch.sample_4 <= s[4];
        scan_ch.sample_5 <= s[5];
        scan_ch.sample_6 <= s[6];
        scan_ch.sample_7 <= s[7];
        do
            @(posedge clk);
        while (!scan_ch.ready);
        drive_pred.take_scan(s);
    endtask

    task automatic source_gap();
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            scan_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        scan_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (drive_pred.pending_drives.size() != 0);
    endtask

    task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        drive_pred.write_reg(idx, data);
    endtask

    task automatic write_settings(drive_settings_t c);
        cfg_beat(REG_PROP_GAIN, c.prop_gain);
        cfg_beat(REG_INTEG_GAIN, c.integ_gain);
        cfg_beat(REG_DERIV_GAIN, c.deriv_gain);
        cfg_beat(REG_BASE_SPEED, c.base_speed);
        cfg_beat(REG_LINE_THRESHOLD, c.line_threshold);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        drive_settings_t phase_cfg [8];
        drive_settings_t c;

        clk              = 1'b0;
        rst_n            = 1'b0;
        gaps_on          = 1'b0;
        sink_stall       = 0;
        scan_ch.valid    = 1'b0;
        scan_ch.sample_0 = '0;
        scan_ch.sample_1 = '0;
        scan_ch.sample_2 = '0;
        scan_ch.sample_3 = '0;
        scan_ch.sample_4 = '0;
        scan_ch.sample_5 = '0;
        scan_ch.sample_6 = '0;
        scan_ch.sample_7 = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        drive_pred       = new();

        // Base speeds are raw 9-bit codes: 16'h0100 is -256, 16'h0101 is -255.
        phase_cfg[0] = '{16'd1920, 16'd26, 16'd640, 16'd70, 16'd800};
        phase_cfg[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'd1023};
        phase_cfg[2] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd512};
        phase_cfg[3] = '{16'd256, 16'd100, 16'd300, 16'h0100, 16'd600};
        phase_cfg[4] = '{16'd0, 16'd0, 16'd0, 16'h0101, 16'd0};
        for (int p = 5; p < 8; p++)
        begin
            phase_cfg[p].prop_gain      = CFG_DATA_W'($urandom_range(0, 4095));
            phase_cfg[p].integ_gain     = CFG_DATA_W'($urandom_range(0, 511));
            phase_cfg[p].deriv_gain     = CFG_DATA_W'($urandom_range(0, 65535));
            phase_cfg[p].base_speed     = CFG_DATA_W'($urandom_range(0, 511));
            phase_cfg[p].line_threshold = CFG_DATA_W'($urandom_range(1, 1023));
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on = 1'b1;
        foreach (LINE_MASKS[k])
        begin
            source_gap();
            send_scan(scan_from_mask(LINE_MASKS[k], 10'd0, 10'd1023));
        end
        send_scan(scan_from_mask(8'h01, 10'd799, 10'd1023));
        send_scan(scan_from_mask(8'h01, 10'd800, 10'd1023));
        wait_drain();

        for (int p = 0; p < 8; p++)
        begin
            write_settings(phase_cfg[p]);
            gaps_on = (p % 3 != 2);
            repeat (150)
            begin
                source_gap();
                send_scan(random_scan(int'(phase_cfg[p].line_threshold[THR_W-1:0])));
            end
            wait_drain();
        end

        // Runs to one side push the integral up and then back down.
        gaps_on = 1'b0;
        c = '{16'd0, 16'd1, 16'd0, 16'd0, 16'd800};
        write_settings(c);
        repeat (40)
            send_scan(scan_from_mask(8'h01, THR_W'($urandom_range(0, 799)),
                                     THR_W'($urandom_range(800, 1023))));
        repeat (40)
            send_scan(scan_from_mask(8'h80, THR_W'($urandom_range(0, 799)),
                                     THR_W'($urandom_range(800, 1023))));
        wait_drain();

        repeat (16) @(posedge clk);
        if (drive_pred.mismatches == 0 && drive_pred.pending_drives.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lfpd_pkg.sv
sv/lfpd_ifs.sv
sv/lfpd_ctrl.sv
sv/lfpd_dp.sv
sv/line_follower_pid_drive.sv
tb/tb_line_follower_pid_drive.sv
